### rtl/hdq_pkg.sv
// Shared types, constants and helpers for the handle deque.
// Used by the datapath, controller, top level and testbench; depends on nothing.
package hdq_pkg;

    // Ring size and derived widths
    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int HDL_W  = 32;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [HDL_W-1:0] hdl_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 2'd0,
        REQ_PUSH_FRONT = 2'd1,
        REQ_POP_BACK   = 2'd2,
        REQ_SEARCH     = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic latch_req;
        logic exec;
        logic scan_next;
        logic set_found;
        logic load_out;
    } hdq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        req_t req;
        logic is_empty;
        logic match;
        logic scan_last;
        logic out_free;
    } hdq_stat_t;

    // Ring slot of base + off, both below DEPTH
    function automatic idx_t slot_add(input idx_t base, input idx_t off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IDX_W+1)'(DEPTH))
        begin
            sum = sum - (IDX_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Ring slot one before base
    function automatic idx_t slot_dec(input idx_t base);
        idx_t res;
        if (base == '0)
        begin
            res = IDX_W'(DEPTH - 1);
        end
        else
        begin
            res = base - IDX_W'(1);
        end
        return res;
    endfunction

endpackage

### rtl/hdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependencies.
module hdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read; hold data between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/hdq_dp.sv
// Datapath of the handle deque: ring pointers, entry RAM, search compare
// and output register. Depends on hdq_pkg and hdq_ram.
module hdq_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  hdq_pkg::hdq_cmd_t cmd,
    output hdq_pkg::hdq_stat_t stat,
    input  logic [1:0]        req_type,
    input  logic [31:0]       handle_in,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [31:0]       handle_out,
    output logic              found,
    output logic              is_empty
);

    hdq_pkg::req_t    req_reg;
    hdq_pkg::hdl_t    handle_reg;
    hdq_pkg::idx_t    front_reg, front_next;
    hdq_pkg::cnt_t    count_reg, count_next;
    hdq_pkg::idx_t    scan_reg, scan_next;
    hdq_pkg::status_t res_status_reg, res_status_next;
    logic             res_found_reg, res_found_next;
    logic             pop_ok_reg, pop_ok_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       status_reg;
    hdq_pkg::hdl_t    handle_out_reg;
    logic             found_reg;
    logic             is_empty_reg;

    logic             full;
    logic             empty;
    logic             ram_we;
    hdq_pkg::idx_t    ram_waddr;
    logic             ram_re;
    hdq_pkg::idx_t    ram_raddr;
    hdq_pkg::hdl_t    ram_rdata;
    hdq_pkg::idx_t    scan_inc;

    assign full     = (count_reg == hdq_pkg::CNT_W'(hdq_pkg::DEPTH));
    assign empty    = (count_reg == '0);
    assign scan_inc = scan_reg + hdq_pkg::IDX_W'(1);

    // Latch the request
    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            req_reg    <= hdq_pkg::req_t'(req_type);
            handle_reg <= handle_in;
        end
    end

    // Execute the request against the ring
    always_comb
    begin
        front_next      = front_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        pop_ok_next     = pop_ok_reg;
        ram_we          = 1'b0;
        ram_waddr       = front_reg;
        ram_re          = 1'b0;
        ram_raddr       = front_reg;
        if (cmd.exec)
        begin
            res_status_next = hdq_pkg::STATUS_DONE;
            res_found_next  = 1'b0;
            pop_ok_next     = 1'b0;
            unique case (req_reg)
                hdq_pkg::REQ_PUSH_BACK:
                begin
                    if (full)
                    begin
                        res_status_next = hdq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = hdq_pkg::slot_add(front_reg,
                                         count_reg[hdq_pkg::IDX_W-1:0]);
                        count_next = count_reg + hdq_pkg::CNT_W'(1);
                    end
                end
                hdq_pkg::REQ_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        res_status_next = hdq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        front_next = hdq_pkg::slot_dec(front_reg);
                        ram_we     = 1'b1;
                        ram_waddr  = front_next;
                        count_next = count_reg + hdq_pkg::CNT_W'(1);
                    end
                end
                hdq_pkg::REQ_POP_BACK:
                begin
                    if (empty)
                    begin
                        res_status_next = hdq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        count_next  = count_reg - hdq_pkg::CNT_W'(1);
                        ram_re      = 1'b1;
                        ram_raddr   = hdq_pkg::slot_add(front_reg,
                                          count_next[hdq_pkg::IDX_W-1:0]);
                        pop_ok_next = 1'b1;
                    end
                end
                hdq_pkg::REQ_SEARCH:
                begin
                    // Start the scan at the front entry
                    scan_next = '0;
                    ram_re    = !empty;
                    ram_raddr = front_reg;
                end
                default:
                begin
                    res_status_next = hdq_pkg::STATUS_DONE;
                end
            endcase
        end
        else if (cmd.scan_next)
        begin
            scan_next = scan_inc;
            ram_re    = 1'b1;
            ram_raddr = hdq_pkg::slot_add(front_reg, scan_inc);
        end
        if (cmd.set_found)
        begin
            res_found_next = 1'b1;
        end
    end

    // Ring pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // Working result
    always_ff @(posedge clk)
    begin
        scan_reg       <= scan_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        pop_ok_reg     <= pop_ok_next;
    end

    hdq_ram #(
        .WIDTH (hdq_pkg::HDL_W),
        .DEPTH (hdq_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (handle_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register: load on finish, drop once taken
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status_reg     <= res_status_reg;
            handle_out_reg <= pop_ok_reg ? ram_rdata : '0;
            found_reg      <= res_found_reg;
            is_empty_reg   <= empty;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign handle_out = handle_out_reg;
    assign found      = found_reg;
    assign is_empty   = is_empty_reg;

    // Status to the controller
    assign stat.req       = req_reg;
    assign stat.is_empty  = empty;
    assign stat.match     = (ram_rdata == handle_reg);
    assign stat.scan_last = ((hdq_pkg::CNT_W'(scan_reg) + hdq_pkg::CNT_W'(1)) == count_reg);
    assign stat.out_free  = !out_valid_reg || !out_stall;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= hdq_pkg::CNT_W'(hdq_pkg::DEPTH))
        else $error("entry count above ring depth");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a pending result");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && !full &&
        (req_reg == hdq_pkg::REQ_PUSH_BACK || req_reg == hdq_pkg::REQ_PUSH_FRONT)
        |=> count_reg == $past(count_reg) + hdq_pkg::CNT_W'(1))
        else $error("push did not grow the queue");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_next |-> !stat.scan_last && !empty)
        else $error("scan advanced beyond the last entry");

endmodule

### rtl/hdq_ctrl.sv
// Controller state machine of the handle deque: sequences accept,
// execute, scan and result hand-off. Depends on hdq_pkg.
module hdq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  hdq_pkg::hdq_stat_t stat,
    output hdq_pkg::hdq_cmd_t  cmd
);

    hdq_pkg::state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hdq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = hdq_pkg::ST_EXEC;
                end
            end
            hdq_pkg::ST_EXEC:
            begin
                if (stat.req == hdq_pkg::REQ_SEARCH && !stat.is_empty)
                begin
                    state_next = hdq_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = hdq_pkg::ST_FINISH;
                end
            end
            hdq_pkg::ST_SCAN:
            begin
                if (stat.match || stat.scan_last)
                begin
                    state_next = hdq_pkg::ST_FINISH;
                end
            end
            hdq_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = hdq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hdq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hdq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands to the datapath
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            hdq_pkg::ST_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.latch_req = in_valid;
            end
            hdq_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            hdq_pkg::ST_SCAN:
            begin
                cmd.set_found = stat.match;
                cmd.scan_next = !stat.match && !stat.scan_last;
            end
            hdq_pkg::ST_FINISH:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == hdq_pkg::ST_EXEC)
        else $error("accepted request not executed next");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.latch_req, cmd.exec, cmd.scan_next, cmd.load_out}))
        else $error("conflicting datapath commands");

endmodule

### rtl/handle_deque_with_search.sv
// Handle deque: push back, push front, pop back and search of a ring.
// A request is latched on accept, executed, and its result loaded into the output
// register before a new request is taken. A search first scans the ring from the
// front, one entry per cycle through one RAM read and compare, up to DEPTH entries.
// A waiting result lets one more request in, which holds until the result is taken.
// Reset (rst_n, asynchronous) empties the queue; RAM contents are not cleared.
module handle_deque_with_search (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [31:0] handle_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] handle_out,
    output logic        found,
    output logic        is_empty
);

    hdq_pkg::hdq_cmd_t  cmd;
    hdq_pkg::hdq_stat_t stat;

    hdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    hdq_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .req_type   (req_type),
        .handle_in  (handle_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .handle_out (handle_out),
        .found      (found),
        .is_empty   (is_empty)
    );

endmodule

### sim/tb_handle_deque_with_search.sv
`timescale 1ns / 1ps
// Testbench for handle_deque_with_search: directed table then random requests, each result checked
// in order against the table's expected result or a model of the ring. Depends on hdq_pkg.
module tb_handle_deque_with_search;

    import hdq_pkg::*;

    localparam int RAND_ITEMS   = 1850;
    localparam int CALM_ITEMS   = 250;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT      = 500;
    localparam int DRAIN_AT     = 1100;
    localparam int SETTLE_TICKS = 3 + DEPTH + 8;

    typedef struct {
        status_t st;
        hdl_t    hout;
        logic    fnd;
        logic    emp;
    } deque_result_t;

    typedef struct {
        req_t          req;
        hdl_t          hdl;
        bit            typed;
        deque_result_t res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic [31:0] handle_in;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [31:0] handle_out;
    logic        found;
    logic        is_empty;

    // Model of the ring
    hdl_t ring_model [DEPTH];
    int   ring_front;
    int   ring_count;

    deque_result_t pending_results [$];
    stim_row_t     directed_rows [$];
    int            err_count;
    bit            calm;
    bit            long_hold;

    handle_deque_with_search dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .handle_in  (handle_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .handle_out (handle_out),
        .found      (found),
        .is_empty   (is_empty)
    );

    // Apply one request to the model and return the result it gives
    function automatic deque_result_t deque_apply(input req_t req, input hdl_t h);
        deque_result_t r;
        r.st   = STATUS_DONE;
        r.hout = '0;
        r.fnd  = 1'b0;
        case (req)
            REQ_PUSH_BACK:
            begin
                if (ring_count >= DEPTH)
                begin
                    r.st = STATUS_FULL;
                end
                else
                begin
                    ring_model[(ring_front + ring_count) % DEPTH] = h;
                    ring_count++;
                end
            end
            REQ_PUSH_FRONT:
            begin
                if (ring_count >= DEPTH)
                begin
                    r.st = STATUS_FULL;
                end
                else
                begin
                    ring_front = (ring_front + DEPTH - 1) % DEPTH;
                    ring_model[ring_front] = h;
                    ring_count++;
                end
            end
            REQ_POP_BACK:
            begin
                if (ring_count == 0)
                begin
                    r.st = STATUS_EMPTY;
                end
                else
                begin
                    r.hout = ring_model[(ring_front + ring_count - 1) % DEPTH];
                    ring_count--;
                end
            end
            default:
            begin
                for (int i = 0; i < ring_count; i++)
                begin
                    if (ring_model[(ring_front + i) % DEPTH] == h)
                    begin
                        r.fnd = 1'b1;
                        break;
                    end
                end
            end
        endcase
        r.emp = (ring_count == 0);
        return r;
    endfunction

    function automatic deque_result_t mk_res(input status_t st, input hdl_t hout,
                                             input logic fnd, input logic emp);
        deque_result_t r;
        r.st   = st;
        r.hout = hout;
        r.fnd  = fnd;
        r.emp  = emp;
        return r;
    endfunction

    task automatic add_row(input req_t req, input hdl_t h, input bit typed,
                           input deque_result_t res);
        stim_row_t row;
        row.req   = req;
        row.hdl   = h;
        row.typed = typed;
        row.res   = res;
        directed_rows.push_back(row);
    endtask

    // Directed table: empty-queue cases, extreme handles, fill to full
    task automatic load_directed();
        deque_result_t none;
        none = mk_res(STATUS_DONE, '0, 1'b0, 1'b0);
        add_row(REQ_POP_BACK,   32'hDEAD_BEEF, 1, mk_res(STATUS_EMPTY, '0, 1'b0, 1'b1));
        add_row(REQ_SEARCH,     32'h0000_0000, 1, mk_res(STATUS_DONE, '0, 1'b0, 1'b1));
        add_row(REQ_PUSH_BACK,  32'h0000_0000, 1, mk_res(STATUS_DONE, '0, 1'b0, 1'b0));
        add_row(REQ_PUSH_FRONT, 32'hFFFF_FFFF, 1, mk_res(STATUS_DONE, '0, 1'b0, 1'b0));
        add_row(REQ_SEARCH,     32'hFFFF_FFFF, 1, mk_res(STATUS_DONE, '0, 1'b1, 1'b0));
        add_row(REQ_SEARCH,     32'h0000_0000, 1, mk_res(STATUS_DONE, '0, 1'b1, 1'b0));
        add_row(REQ_SEARCH,     32'h1234_5678, 0, none);
        add_row(REQ_POP_BACK,   32'h5555_5555, 1, mk_res(STATUS_DONE, '0, 1'b0, 1'b0));
        // Fill the ring from both ends, with one duplicate handle
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            add_row((i % 2) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
                    (i == 5) ? 32'hFFFF_FFFF : (32'h1 << (2 * i)), 0, none);
        end
        add_row(REQ_PUSH_BACK,  32'hAAAA_AAAA, 1, mk_res(STATUS_FULL, '0, 1'b0, 1'b0));
        add_row(REQ_PUSH_FRONT, 32'h5555_5555, 1, mk_res(STATUS_FULL, '0, 1'b0, 1'b0));
        add_row(REQ_SEARCH,     32'h1 << (2 * (DEPTH - 2)), 0, none);
        add_row(REQ_POP_BACK,   32'h0, 0, none);
    endtask

    // Offer one request and hold it until accepted; record what it should give
    task automatic offer_request(input req_t req, input hdl_t h, input bit typed,
                                 input deque_result_t typed_res);
        deque_result_t r;
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        req_type  <= req;
        handle_in <= h;
        do
            @(posedge clk);
        while (in_stall);
        r = deque_apply(req, h);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    // Pick a request; the mode biases the ring towards filling, draining or neither
    task automatic pick_request(input int mode, output req_t req, output hdl_t h);
        int roll;
        int pick;
        roll = $urandom_range(0, 99);
        if (roll < 25)
        begin
            req = REQ_SEARCH;
        end
        else if (roll < 25 + ((mode == 0) ? 55 : (mode == 1) ? 20 : 38))
        begin
            req = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
        end
        else
        begin
            req = REQ_POP_BACK;
        end
        pick = $urandom_range(0, 7);
        if (req == REQ_SEARCH && ring_count > 0 && pick < 5)
        begin
            h = ring_model[(ring_front + $urandom_range(0, ring_count - 1)) % DEPTH];
        end
        else if (pick == 0)
        begin
            h = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        end
        else if (pick < 3)
        begin
            h = $urandom_range(0, 7);
        end
        else
        begin
            h = $urandom;
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Sender: reset, directed table, random requests, drain
    initial
    begin
        req_t          req;
        hdl_t          h;
        int            mode;
        deque_result_t none;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        req_type   = REQ_PUSH_BACK;
        handle_in  = '0;
        err_count  = 0;
        calm       = 1'b0;
        long_hold  = 1'b0;
        ring_front = 0;
        ring_count = 0;
        mode       = 2;
        none       = mk_res(STATUS_DONE, '0, 1'b0, 1'b0);
        for (int i = 0; i < DEPTH; i++)
        begin
            ring_model[i] = '0;
        end
        load_directed();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            offer_request(directed_rows[i].req, directed_rows[i].hdl,
                          directed_rows[i].typed, directed_rows[i].res);
        end

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                mode = $urandom_range(0, 2);
            end
            if (n == HOLD_AT)
            begin
                long_hold = 1'b1;
            end
            if (n == RAND_ITEMS - CALM_ITEMS)
            begin
                calm = 1'b1;
            end
            // Pause until every outstanding result has come back
            if (n == DRAIN_AT)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            pick_request(mode, req, h);
            offer_request(req, h, 1'b0, none);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
        if (err_count == 0)
        begin
            $display("tb_handle_deque_with_search: done, clean");
        end
        else
        begin
            $display("tb_handle_deque_with_search: done, errors");
        end
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off, none in the calm part
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 1'b0;
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: status %0d handle_out %h",
                       status, handle_out);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    err_count++;
                end
                if (handle_out !== want.hout)
                begin
                    $error("handle_out: expected %h, got %h", want.hout, handle_out);
                    err_count++;
                end
                if (found !== want.fnd)
                begin
                    $error("found: expected %0b, got %0b", want.fnd, found);
                    err_count++;
                end
                if (is_empty !== want.emp)
                begin
                    $error("is_empty: expected %0b, got %0b", want.emp, is_empty);
                    err_count++;
                end
            end
        end
    end

    // Stop a hung run
    initial
    begin
        #10_000_000;
        $display("tb_handle_deque_with_search: done, errors");
        $finish;
    end

endmodule
